[rtl/source_tokenizer_top_assert.svh]
// Assertion macros used by the tokenizer top level.
// Each macro expects signals clk and rst_n in the scope of its use.
`ifndef SOURCE_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SRCTOK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SRCTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/srctok_pkg.sv]
// Types, constants and helper functions of the source tokenizer.
// Used by the output channel interface, the scanner and the top level.
package srctok_pkg;

  localparam int POS_BITS     = 32;
  localparam int LEN_BITS     = 16;
  localparam int VAL_BITS     = 63;
  localparam int KIND_BITS    = 4;
  localparam int MAX_RES      = 3;
  localparam int RES_IDX_BITS = $clog2(MAX_RES);
  localparam int RES_CNT_BITS = $clog2(MAX_RES + 1);

  localparam logic [VAL_BITS-1:0] INT32_TOP = VAL_BITS'(32'h7fff_ffff);
  localparam logic [VAL_BITS-1:0] INT64_TOP = '1;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_BIG_L = 8'h4c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3b;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_EOF     = 4'd0,
    KIND_ENTRY   = 4'd1,
    KIND_RETURN  = 4'd2,
    KIND_IDENT   = 4'd3,
    KIND_LBRACE  = 4'd4,
    KIND_RBRACE  = 4'd5,
    KIND_LPAREN  = 4'd6,
    KIND_RPAREN  = 4'd7,
    KIND_SEMI    = 4'd8,
    KIND_INT     = 4'd9,
    KIND_LLONG   = 4'd10,
    KIND_FLOAT   = 4'd11,
    KIND_DOUBLE  = 4'd12,
    KIND_INVALID = 4'd13,
    KIND_UNKNOWN = 4'd14
  } tok_kind_t;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_IDENT   = 6'b000010,
    MODE_NUM     = 6'b000100,
    MODE_NUM_L   = 6'b001000,
    MODE_SLASH   = 6'b010000,
    MODE_COMMENT = 6'b100000
  } scan_mode_t;

  typedef enum logic [1:0] {
    SUF_NONE = 2'd0,
    SUF_F    = 2'd1,
    SUF_LL   = 2'd2
  } suffix_t;

  typedef struct packed {
    tok_kind_t             kind;
    logic [POS_BITS-1:0]   start;
    logic [LEN_BITS-1:0]   len;
    logic [VAL_BITS-1:0]   value;
    logic                  ovf;
    logic                  last;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_RES-1:0]      slot;
    logic [RES_CNT_BITS-1:0] cnt;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0d]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic [7:0] entry_char(input logic [2:0] k);
    logic [7:0] ch;
    case (k)
      3'd0:    ch = 8'h65;
      3'd1:    ch = 8'h6e;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h72;
      3'd4:    ch = 8'h79;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] return_char(input logic [2:0] k);
    logic [7:0] ch;
    case (k)
      3'd0:    ch = 8'h72;
      3'd1:    ch = 8'h65;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h75;
      3'd4:    ch = 8'h72;
      3'd5:    ch = 8'h6e;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                  input logic [1:0] b);
    logic [LEN_BITS:0] s;
    s = {1'b0, a} + (LEN_BITS + 1)'(b);
    return s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
  endfunction

  function automatic tok_t mk_tok(input tok_kind_t kind, input logic [POS_BITS-1:0] start,
                                  input logic [LEN_BITS-1:0] len);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.value = '0;
    t.ovf   = 1'b0;
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic tok_t ident_tok(input logic [POS_BITS-1:0] start,
                                     input logic [LEN_BITS-1:0] len, input logic [1:0] kw);
    tok_kind_t k;
    if (kw[0] && (len == LEN_BITS'(5))) begin
      k = KIND_ENTRY;
    end else if (kw[1] && (len == LEN_BITS'(6))) begin
      k = KIND_RETURN;
    end else begin
      k = KIND_IDENT;
    end
    return mk_tok(k, start, len);
  endfunction

  function automatic tok_t num_tok(input logic [POS_BITS-1:0] start,
                                   input logic [LEN_BITS-1:0] run,
                                   input logic [VAL_BITS-1:0] acc, input logic seen_dot,
                                   input logic dot_err, input logic acc_ovf,
                                   input suffix_t suf);
    tok_t t;
    logic ovf;
    t = mk_tok(KIND_INT, start, sat_add(run, suf));
    if (dot_err) begin
      t.kind = KIND_INVALID;
    end else if (suf == SUF_F) begin
      t.kind = KIND_FLOAT;
    end else if (seen_dot) begin
      t.kind = KIND_DOUBLE;
    end else begin
      if (suf == SUF_LL) begin
        t.kind = KIND_LLONG;
        ovf    = acc_ovf;
      end else begin
        ovf    = acc_ovf || (acc > INT32_TOP);
      end
      t.ovf   = ovf;
      t.value = ovf ? '0 : acc;
    end
    return t;
  endfunction

  function automatic res_t res_push(input res_t r, input tok_t t);
    res_t o;
    o = r;
    if (r.cnt < RES_CNT_BITS'(MAX_RES)) begin
      o.slot[RES_IDX_BITS'(r.cnt)] = t;
      o.cnt = r.cnt + 1'b1;
    end
    return o;
  endfunction

endpackage

[rtl/srctok_in_if.sv]
// Input byte channel of the tokenizer: valid/ready with byte and end flag.
// Does not depend on srctok_pkg.
interface srctok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

[rtl/srctok_out_if.sv]
// Token result channel of the tokenizer: valid/ready with token fields.
// Field widths come from srctok_pkg.
interface srctok_out_if;
  logic                              valid;
  logic                              ready;
  logic [srctok_pkg::KIND_BITS-1:0]  token_kind;
  logic [srctok_pkg::POS_BITS-1:0]   token_start;
  logic [srctok_pkg::LEN_BITS-1:0]   token_length;
  logic [srctok_pkg::VAL_BITS-1:0]   literal_value;
  logic                              value_overflow;
  logic                              run_last;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output literal_value, output value_overflow, output run_last,
                  input ready);
  modport sink   (input valid, input token_kind, input token_start, input token_length,
                  input literal_value, input value_overflow, input run_last,
                  output ready);
endinterface

[rtl/source_tokenizer_top.sv]
// Source tokenizer top level: byte register, scanner step, token group register.
// Path: a completing byte passes the byte register and then the token group register before its token can transfer.
// Throughput: one byte per cycle while the output is ready and each byte yields at most one
// token; a byte that yields tokens waits until the previous token group has drained.
// Reset: synchronous, active low; clears the scanner to idle at offset zero and drops
// any held byte or token group.
module source_tokenizer_top (
  input  logic            clk,
  input  logic            rst_n,
  srctok_in_if.sink       in_ch,
  srctok_out_if.source    out_ch
);

  `include "source_tokenizer_top_assert.svh"

  logic                                   inq_valid_r;
  logic [7:0]                             inq_byte_r;
  logic                                   inq_last_r;

  srctok_pkg::res_t                       res;
  srctok_pkg::res_t                       grp_r;
  logic                                   grp_valid_r;
  logic [srctok_pkg::RES_IDX_BITS-1:0]    head_r;
  srctok_pkg::tok_t                       cur;

  logic                                   out_fire;
  logic                                   head_done;
  logic                                   grp_free;
  logic                                   proc_fire;

  srctok_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (proc_fire),
    .char_byte   (inq_byte_r),
    .end_of_text (inq_last_r),
    .res         (res)
  );

  assign cur       = grp_r.slot[head_r];
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign head_done = (srctok_pkg::RES_CNT_BITS'(head_r) == grp_r.cnt - 1'b1);
  assign grp_free  = !grp_valid_r || (out_fire && head_done);
  assign proc_fire = inq_valid_r && ((res.cnt == '0) || grp_free);

  assign in_ch.ready = !inq_valid_r || proc_fire;

  assign out_ch.valid          = grp_valid_r;
  assign out_ch.token_kind     = cur.kind;
  assign out_ch.token_start    = cur.start;
  assign out_ch.token_length   = cur.len;
  assign out_ch.literal_value  = cur.value;
  assign out_ch.value_overflow = cur.ovf;
  assign out_ch.run_last       = cur.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      inq_valid_r <= 1'b1;
    end else if (proc_fire) begin
      inq_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      inq_byte_r <= in_ch.char_byte;
      inq_last_r <= in_ch.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      head_r      <= '0;
    end else if (proc_fire && (res.cnt != '0)) begin
      grp_valid_r <= 1'b1;
      head_r      <= '0;
    end else if (out_fire) begin
      if (head_done) begin
        grp_valid_r <= 1'b0;
        head_r      <= '0;
      end else begin
        head_r      <= head_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && (res.cnt != '0)) begin
      grp_r <= res;
    end
  end

  `SRCTOK_ASSERT_NOW(a_grp_nonempty, grp_valid_r, (grp_r.cnt != '0) && (srctok_pkg::RES_CNT_BITS'(head_r) < grp_r.cnt), "token group empty or head past its count")
  `SRCTOK_ASSERT_NOW(a_last_marks_tail, grp_valid_r, cur.last == head_done, "run_last does not mark the final token of the byte")
  `SRCTOK_ASSERT_NOW(a_eof_is_last, grp_valid_r && (cur.kind == srctok_pkg::KIND_EOF), cur.last && (cur.len == '0), "end-of-file token is not the last result of its byte")
  `SRCTOK_ASSERT_NEXT(a_group_load, proc_fire && (res.cnt != '0), grp_valid_r && (head_r == '0), "token group not loaded after a scanner step")

endmodule

[rtl/srctok_scan.sv]
// Scanner state and per-byte step: holds the lexer state, forms up to three tokens.
// Depends on srctok_pkg.
module srctok_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        char_byte,
  input  logic              end_of_text,
  output srctok_pkg::res_t  res
);

  srctok_pkg::scan_mode_t                mode_r, mode_nxt;
  logic [srctok_pkg::POS_BITS-1:0]       start_r, start_nxt;
  logic [srctok_pkg::LEN_BITS-1:0]       run_r, run_nxt;
  logic [srctok_pkg::VAL_BITS-1:0]       acc_r, acc_nxt;
  logic                                  seen_dot_r, seen_dot_nxt;
  logic                                  dot_err_r, dot_err_nxt;
  logic [1:0]                            kw_r, kw_nxt;
  logic [srctok_pkg::POS_BITS-1:0]       pos_r, pos_nxt;
  logic                                  acc_ovf_r, acc_ovf_nxt;

  logic [srctok_pkg::VAL_BITS+3:0]       acc_x10;
  logic                                  redo;
  logic                                  do_ident;
  srctok_pkg::res_t                      r;

  assign acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                 + (srctok_pkg::VAL_BITS + 4)'(char_byte[3:0]);

  always_comb begin
    mode_nxt     = mode_r;
    start_nxt    = start_r;
    run_nxt      = run_r;
    acc_nxt      = acc_r;
    seen_dot_nxt = seen_dot_r;
    dot_err_nxt  = dot_err_r;
    kw_nxt       = kw_r;
    acc_ovf_nxt  = acc_ovf_r;
    pos_nxt      = pos_r + 1'b1;
    redo         = 1'b0;
    do_ident     = 1'b0;
    r            = '0;

    case (mode_r)
      srctok_pkg::MODE_COMMENT: begin
        if ((char_byte == srctok_pkg::CH_LF) || (char_byte == srctok_pkg::CH_CR)) begin
          mode_nxt = srctok_pkg::MODE_IDLE;
        end
      end
      srctok_pkg::MODE_SLASH: begin
        if (char_byte == srctok_pkg::CH_SLASH) begin
          mode_nxt = srctok_pkg::MODE_COMMENT;
        end else begin
          r    = srctok_pkg::res_push(r, srctok_pkg::mk_tok(srctok_pkg::KIND_UNKNOWN,
                                                            start_r, 16'd1));
          redo = 1'b1;
        end
      end
      srctok_pkg::MODE_NUM_L: begin
        if (char_byte == srctok_pkg::CH_BIG_L) begin
          r = srctok_pkg::res_push(r, srctok_pkg::num_tok(start_r, run_r, acc_r, seen_dot_r,
                                                         dot_err_r, acc_ovf_r,
                                                         srctok_pkg::SUF_LL));
          mode_nxt = srctok_pkg::MODE_IDLE;
        end else begin
          r = srctok_pkg::res_push(r, srctok_pkg::num_tok(start_r, run_r, acc_r, seen_dot_r,
                                                         dot_err_r, acc_ovf_r,
                                                         srctok_pkg::SUF_NONE));
          mode_nxt  = srctok_pkg::MODE_IDENT;
          start_nxt = pos_r - 1'b1;
          run_nxt   = srctok_pkg::LEN_BITS'(1);
          kw_nxt    = 2'b00;
          do_ident  = 1'b1;
        end
      end
      srctok_pkg::MODE_IDENT: begin
        do_ident = 1'b1;
      end
      srctok_pkg::MODE_NUM: begin
        if (srctok_pkg::is_digit(char_byte)) begin
          if (acc_x10 > {4'b0000, srctok_pkg::INT64_TOP}) begin
            acc_ovf_nxt = 1'b1;
          end else begin
            acc_nxt = acc_x10[srctok_pkg::VAL_BITS-1:0];
          end
          run_nxt = srctok_pkg::sat_add(run_r, 2'd1);
        end else if (char_byte == srctok_pkg::CH_DOT) begin
          if (seen_dot_r) begin
            dot_err_nxt = 1'b1;
          end
          seen_dot_nxt = 1'b1;
          run_nxt      = srctok_pkg::sat_add(run_r, 2'd1);
        end else if ((char_byte == srctok_pkg::CH_F) && seen_dot_r) begin
          r = srctok_pkg::res_push(r, srctok_pkg::num_tok(start_r, run_r, acc_r, seen_dot_r,
                                                         dot_err_r, acc_ovf_r,
                                                         srctok_pkg::SUF_F));
          mode_nxt = srctok_pkg::MODE_IDLE;
        end else if (char_byte == srctok_pkg::CH_BIG_L) begin
          mode_nxt = srctok_pkg::MODE_NUM_L;
        end else begin
          r = srctok_pkg::res_push(r, srctok_pkg::num_tok(start_r, run_r, acc_r, seen_dot_r,
                                                         dot_err_r, acc_ovf_r,
                                                         srctok_pkg::SUF_NONE));
          mode_nxt = srctok_pkg::MODE_IDLE;
          redo     = 1'b1;
        end
      end
      default: begin
        redo = 1'b1;
      end
    endcase

    if (do_ident) begin
      if (srctok_pkg::is_word(char_byte)) begin
        if (!((run_nxt < 16'd5) && (srctok_pkg::entry_char(run_nxt[2:0]) == char_byte))) begin
          kw_nxt[0] = 1'b0;
        end
        if (!((run_nxt < 16'd6) && (srctok_pkg::return_char(run_nxt[2:0]) == char_byte))) begin
          kw_nxt[1] = 1'b0;
        end
        run_nxt = srctok_pkg::sat_add(run_nxt, 2'd1);
      end else begin
        r        = srctok_pkg::res_push(r, srctok_pkg::ident_tok(start_nxt, run_nxt, kw_nxt));
        mode_nxt = srctok_pkg::MODE_IDLE;
        redo     = 1'b1;
      end
    end

    if (redo) begin
      mode_nxt = srctok_pkg::MODE_IDLE;
      if (srctok_pkg::is_space(char_byte)) begin
        mode_nxt = srctok_pkg::MODE_IDLE;
      end else if (char_byte == srctok_pkg::CH_SLASH) begin
        mode_nxt  = srctok_pkg::MODE_SLASH;
        start_nxt = pos_r;
      end else if (char_byte == srctok_pkg::CH_LBRACE) begin
        r = srctok_pkg::res_push(r, srctok_pkg::mk_tok(srctok_pkg::KIND_LBRACE, pos_r, 16'd1));
      end else if (char_byte == srctok_pkg::CH_RBRACE) begin
        r = srctok_pkg::res_push(r, srctok_pkg::mk_tok(srctok_pkg::KIND_RBRACE, pos_r, 16'd1));
      end else if (char_byte == srctok_pkg::CH_LPAREN) begin
        r = srctok_pkg::res_push(r, srctok_pkg::mk_tok(srctok_pkg::KIND_LPAREN, pos_r, 16'd1));
      end else if (char_byte == srctok_pkg::CH_RPAREN) begin
        r = srctok_pkg::res_push(r, srctok_pkg::mk_tok(srctok_pkg::KIND_RPAREN, pos_r, 16'd1));
      end else if (char_byte == srctok_pkg::CH_SEMI) begin
        r = srctok_pkg::res_push(r, srctok_pkg::mk_tok(srctok_pkg::KIND_SEMI, pos_r, 16'd1));
      end else if (srctok_pkg::is_alpha(char_byte) || (char_byte == srctok_pkg::CH_UNDER)) begin
        mode_nxt  = srctok_pkg::MODE_IDENT;
        start_nxt = pos_r;
        kw_nxt    = 2'b11;
        if (srctok_pkg::entry_char(3'd0) != char_byte) begin
          kw_nxt[0] = 1'b0;
        end
        if (srctok_pkg::return_char(3'd0) != char_byte) begin
          kw_nxt[1] = 1'b0;
        end
        run_nxt = srctok_pkg::LEN_BITS'(1);
      end else if (srctok_pkg::is_digit(char_byte)) begin
        mode_nxt     = srctok_pkg::MODE_NUM;
        start_nxt    = pos_r;
        run_nxt      = srctok_pkg::LEN_BITS'(1);
        acc_nxt      = srctok_pkg::VAL_BITS'(char_byte[3:0]);
        seen_dot_nxt = 1'b0;
        dot_err_nxt  = 1'b0;
        acc_ovf_nxt  = 1'b0;
      end else begin
        r = srctok_pkg::res_push(r, srctok_pkg::mk_tok(srctok_pkg::KIND_UNKNOWN, pos_r, 16'd1));
      end
    end

    if (end_of_text) begin
      case (mode_nxt)
        srctok_pkg::MODE_IDENT: begin
          r = srctok_pkg::res_push(r, srctok_pkg::ident_tok(start_nxt, run_nxt, kw_nxt));
        end
        srctok_pkg::MODE_NUM: begin
          r = srctok_pkg::res_push(r, srctok_pkg::num_tok(start_nxt, run_nxt, acc_nxt,
                                                         seen_dot_nxt, dot_err_nxt, acc_ovf_nxt,
                                                         srctok_pkg::SUF_NONE));
        end
        srctok_pkg::MODE_NUM_L: begin
          r = srctok_pkg::res_push(r, srctok_pkg::num_tok(start_nxt, run_nxt, acc_nxt,
                                                         seen_dot_nxt, dot_err_nxt, acc_ovf_nxt,
                                                         srctok_pkg::SUF_NONE));
          r = srctok_pkg::res_push(r, srctok_pkg::mk_tok(srctok_pkg::KIND_IDENT, pos_r, 16'd1));
        end
        srctok_pkg::MODE_SLASH: begin
          r = srctok_pkg::res_push(r, srctok_pkg::mk_tok(srctok_pkg::KIND_UNKNOWN,
                                                          start_nxt, 16'd1));
        end
        default: begin
          r = r;
        end
      endcase
      if (r.cnt == srctok_pkg::RES_CNT_BITS'(srctok_pkg::MAX_RES)) begin
        r.cnt = r.cnt - 1'b1;
      end
      r = srctok_pkg::res_push(r, srctok_pkg::mk_tok(srctok_pkg::KIND_EOF, pos_r + 1'b1,
                                                      '0));
      mode_nxt     = srctok_pkg::MODE_IDLE;
      start_nxt    = '0;
      run_nxt      = '0;
      acc_nxt      = '0;
      seen_dot_nxt = 1'b0;
      dot_err_nxt  = 1'b0;
      kw_nxt       = 2'b11;
      pos_nxt      = '0;
      acc_ovf_nxt  = 1'b0;
    end

    if (r.cnt != '0) begin
      r.slot[srctok_pkg::RES_IDX_BITS'(r.cnt - 1'b1)].last = 1'b1;
    end
    res = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= srctok_pkg::MODE_IDLE;
      start_r    <= '0;
      run_r      <= '0;
      acc_r      <= '0;
      seen_dot_r <= 1'b0;
      dot_err_r  <= 1'b0;
      kw_r       <= 2'b11;
      pos_r      <= '0;
      acc_ovf_r  <= 1'b0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      start_r    <= start_nxt;
      run_r      <= run_nxt;
      acc_r      <= acc_nxt;
      seen_dot_r <= seen_dot_nxt;
      dot_err_r  <= dot_err_nxt;
      kw_r       <= kw_nxt;
      pos_r      <= pos_nxt;
      acc_ovf_r  <= acc_ovf_nxt;
    end
  end

endmodule

[tb/source_tokenizer_top_test.sv]
// Self-checking testbench for source_tokenizer_top: byte stream in, token results out.
// Depends on srctok_pkg, srctok_in_if, srctok_out_if and the tokenizer RTL.
module source_tokenizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          RANDOM_BYTES = 230;
  localparam int          DRAIN_CYCLES = 10;
  localparam logic [7:0]  CH_TAB = 8'h09;
  localparam logic [7:0]  CH_VT = 8'h0b;
  localparam logic [7:0]  CH_FF = 8'h0c;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [63:0] LLONG_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [62:0] INT_MAX = 63'h7fff_ffff;

  typedef enum {
    P_ENTRY, P_RETURN, P_NEAR_KW, P_IDENT, P_PUNCT, P_INT, P_EDGE_NUM, P_FLOAT,
    P_DOUBLE, P_INVALID, P_LLONG, P_LONE_L, P_COMMENT, P_SLASH, P_NOISE, P_SPACE
  } piece_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLE} rx_pattern_t;

  class token_scoreboard;
    srctok_pkg::tok_t       token_q[$];
    srctok_pkg::tok_t       step_q[$];
    srctok_pkg::scan_mode_t mode;
    logic [31:0] tok_start;
    logic [31:0] byte_pos;
    logic [15:0] run_len;
    logic [62:0] acc;
    logic        has_dot;
    logic        dot_bad;
    logic        acc_ovf;
    logic [1:0]  kw_live;
    string       entry_word = "entry";
    string       return_word = "return";
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = srctok_pkg::MODE_IDLE;
      tok_start = '0;
      byte_pos = '0;
      run_len = '0;
      acc = '0;
      has_dot = 1'b0;
      dot_bad = 1'b0;
      acc_ovf = 1'b0;
      kw_live = 2'b11;
    endfunction

    function int pending();
      return token_q.size();
    endfunction

    function logic [15:0] len_plus(logic [15:0] a, int b);
      logic [16:0] s;
      s = {1'b0, a} + 17'(b);
      return s[16] ? 16'hffff : s[15:0];
    endfunction

    function bit space_char(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= srctok_pkg::CH_CR);
    endfunction

    function bit digit_char(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit letter_char(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function void push_tok(srctok_pkg::tok_kind_t k, logic [31:0] s, logic [15:0] l,
                           logic [62:0] v, logic o);
      srctok_pkg::tok_t t;
      if (step_q.size() >= srctok_pkg::MAX_RES) return;
      t.kind = k;
      t.start = s;
      t.len = l;
      t.value = v;
      t.ovf = o;
      t.last = 1'b0;
      step_q.insert(step_q.size(), t);
    endfunction

    function void take_ident_char(logic [7:0] c);
      if (!(run_len < 5 && c == entry_word[run_len])) kw_live[0] = 1'b0;
      if (!(run_len < 6 && c == return_word[run_len])) kw_live[1] = 1'b0;
      run_len = len_plus(run_len, 1);
    endfunction

    function void close_ident();
      srctok_pkg::tok_kind_t k;
      k = srctok_pkg::KIND_IDENT;
      if (kw_live[0] && run_len == 16'd5) k = srctok_pkg::KIND_ENTRY;
      else if (kw_live[1] && run_len == 16'd6) k = srctok_pkg::KIND_RETURN;
      push_tok(k, tok_start, run_len, '0, 1'b0);
    endfunction

    function void close_number(srctok_pkg::suffix_t suf);
      logic [15:0] l;
      logic        o;
      l = len_plus(run_len, int'(suf));
      if (dot_bad) push_tok(srctok_pkg::KIND_INVALID, tok_start, l, '0, 1'b0);
      else if (suf == srctok_pkg::SUF_F) push_tok(srctok_pkg::KIND_FLOAT, tok_start, l, '0, 1'b0);
      else if (has_dot) push_tok(srctok_pkg::KIND_DOUBLE, tok_start, l, '0, 1'b0);
      else if (suf == srctok_pkg::SUF_LL) begin
        o = acc_ovf;
        push_tok(srctok_pkg::KIND_LLONG, tok_start, l, o ? '0 : acc, o);
      end else begin
        o = acc_ovf || acc > INT_MAX;
        push_tok(srctok_pkg::KIND_INT, tok_start, l, o ? '0 : acc, o);
      end
    endfunction

    function void start_fresh(logic [7:0] c, logic [31:0] pos);
      mode = srctok_pkg::MODE_IDLE;
      if (space_char(c)) return;
      case (c)
        srctok_pkg::CH_SLASH: begin
          mode = srctok_pkg::MODE_SLASH;
          tok_start = pos;
        end
        srctok_pkg::CH_LBRACE: push_tok(srctok_pkg::KIND_LBRACE, pos, 16'd1, '0, 1'b0);
        srctok_pkg::CH_RBRACE: push_tok(srctok_pkg::KIND_RBRACE, pos, 16'd1, '0, 1'b0);
        srctok_pkg::CH_LPAREN: push_tok(srctok_pkg::KIND_LPAREN, pos, 16'd1, '0, 1'b0);
        srctok_pkg::CH_RPAREN: push_tok(srctok_pkg::KIND_RPAREN, pos, 16'd1, '0, 1'b0);
        srctok_pkg::CH_SEMI: push_tok(srctok_pkg::KIND_SEMI, pos, 16'd1, '0, 1'b0);
        default: begin
          if (letter_char(c) || c == srctok_pkg::CH_UNDER) begin
            mode = srctok_pkg::MODE_IDENT;
            tok_start = pos;
            run_len = '0;
            kw_live = 2'b11;
            take_ident_char(c);
          end else if (digit_char(c)) begin
            mode = srctok_pkg::MODE_NUM;
            tok_start = pos;
            run_len = 16'd1;
            acc = 63'(c - "0");
            has_dot = 1'b0;
            dot_bad = 1'b0;
            acc_ovf = 1'b0;
          end else begin
            push_tok(srctok_pkg::KIND_UNKNOWN, pos, 16'd1, '0, 1'b0);
          end
        end
      endcase
    endfunction

    function bit ident_byte(logic [7:0] c);
      if (letter_char(c) || digit_char(c) || c == srctok_pkg::CH_UNDER) begin
        take_ident_char(c);
        return 1'b0;
      end
      close_ident();
      mode = srctok_pkg::MODE_IDLE;
      return 1'b1;
    endfunction

    function bit number_byte(logic [7:0] c);
      logic [63:0] d;
      if (digit_char(c)) begin
        d = 64'(c - "0");
        if ({1'b0, acc} > (LLONG_MAX - d) / 64'd10) acc_ovf = 1'b1;
        else acc = 63'({1'b0, acc} * 64'd10 + d);
        run_len = len_plus(run_len, 1);
        return 1'b0;
      end
      if (c == srctok_pkg::CH_DOT) begin
        if (has_dot) dot_bad = 1'b1;
        has_dot = 1'b1;
        run_len = len_plus(run_len, 1);
        return 1'b0;
      end
      if (c == srctok_pkg::CH_F && has_dot) begin
        close_number(srctok_pkg::SUF_F);
        mode = srctok_pkg::MODE_IDLE;
        return 1'b0;
      end
      if (c == srctok_pkg::CH_BIG_L) begin
        mode = srctok_pkg::MODE_NUM_L;
        return 1'b0;
      end
      close_number(srctok_pkg::SUF_NONE);
      mode = srctok_pkg::MODE_IDLE;
      return 1'b1;
    endfunction

    function void note_byte(logic [7:0] c, logic eot);
      logic [31:0] pos;
      bit          redo;
      pos = byte_pos;
      redo = 1'b0;
      step_q.delete();
      case (mode)
        srctok_pkg::MODE_COMMENT: begin
          if (c == srctok_pkg::CH_LF || c == srctok_pkg::CH_CR) mode = srctok_pkg::MODE_IDLE;
        end
        srctok_pkg::MODE_SLASH: begin
          if (c == srctok_pkg::CH_SLASH) mode = srctok_pkg::MODE_COMMENT;
          else begin
            push_tok(srctok_pkg::KIND_UNKNOWN, tok_start, 16'd1, '0, 1'b0);
            redo = 1'b1;
          end
        end
        srctok_pkg::MODE_NUM_L: begin
          if (c == srctok_pkg::CH_BIG_L) begin
            close_number(srctok_pkg::SUF_LL);
            mode = srctok_pkg::MODE_IDLE;
          end else begin
            close_number(srctok_pkg::SUF_NONE);
            mode = srctok_pkg::MODE_IDENT;
            tok_start = pos - 32'd1;
            run_len = 16'd1;
            kw_live = 2'b00;
            redo = ident_byte(c);
          end
        end
        srctok_pkg::MODE_IDENT: redo = ident_byte(c);
        srctok_pkg::MODE_NUM: redo = number_byte(c);
        default: redo = 1'b1;
      endcase
      if (redo) start_fresh(c, pos);
      if (eot) begin
        case (mode)
          srctok_pkg::MODE_IDENT: close_ident();
          srctok_pkg::MODE_NUM: close_number(srctok_pkg::SUF_NONE);
          srctok_pkg::MODE_NUM_L: begin
            close_number(srctok_pkg::SUF_NONE);
            push_tok(srctok_pkg::KIND_IDENT, pos, 16'd1, '0, 1'b0);
          end
          srctok_pkg::MODE_SLASH: push_tok(srctok_pkg::KIND_UNKNOWN, tok_start, 16'd1, '0, 1'b0);
          default: ;
        endcase
        // keep end-of-file as the final token of the step
        if (step_q.size() >= srctok_pkg::MAX_RES) void'(step_q.pop_back());
        push_tok(srctok_pkg::KIND_EOF, pos + 32'd1, 16'd0, '0, 1'b0);
        clear();
      end else begin
        byte_pos = pos + 32'd1;
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) token_q.insert(token_q.size(), step_q[i]);
    endfunction

    function void check_token(srctok_pkg::tok_t got);
      srctok_pkg::tok_t want;
      if (token_q.size() == 0) begin
        $error("token transfer with no token pending: kind %0d start %0d",
               got.kind, got.start);
        errors++;
        return;
      end
      want = token_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("token_kind expected %0d actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.start !== want.start) begin
        $error("token_start expected %0d actual %0d", want.start, got.start);
        errors++;
      end
      if (got.len !== want.len) begin
        $error("token_length expected %0d actual %0d", want.len, got.len);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("literal_value expected %0d actual %0d", want.value, got.value);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $error("value_overflow expected %0b actual %0b", want.ovf, got.ovf);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("run_last expected %0b actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  srctok_in_if  in_ch();
  srctok_out_if out_ch();

  source_tokenizer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  token_scoreboard sb = new();
  logic [7:0]      text_q[$];
  logic [7:0]      blanks[6] = '{CH_SPACE, CH_TAB, srctok_pkg::CH_LF, CH_VT, CH_FF,
                                 srctok_pkg::CH_CR};
  logic [7:0]      puncts[5] = '{srctok_pkg::CH_LBRACE, srctok_pkg::CH_RBRACE,
                                 srctok_pkg::CH_LPAREN, srctok_pkg::CH_RPAREN,
                                 srctok_pkg::CH_SEMI};
  int              burst_left = 0;
  int              cycles = 0;
  rx_pattern_t     rx_pattern = RX_OPEN;
  int              rx_left = 0;
  int              rx_phase = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 80);
    end
    rx_left--;
    rx_phase++;
    case (rx_pattern)
      RX_OPEN: out_ch.ready = 1'b1;
      RX_COIN: out_ch.ready = 1'($urandom_range(0, 1));
      RX_SPARSE: out_ch.ready = ($urandom_range(0, 3) == 0);
      default: out_ch.ready = (rx_phase % 5) < 3;
    endcase
  end

  always @(posedge clk) begin
    srctok_pkg::tok_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind = srctok_pkg::tok_kind_t'(out_ch.token_kind);
      got.start = out_ch.token_start;
      got.len = out_ch.token_length;
      got.value = out_ch.literal_value;
      got.ovf = out_ch.value_overflow;
      got.last = out_ch.run_last;
      sb.check_token(got);
    end
  end

  task send_byte(input logic [7:0] c, input logic eot, input bit steady);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.char_byte = c;
    in_ch.end_of_text = eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(c, eot);
    @(negedge clk);
  endtask

  task send_text(input bit steady);
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1, steady);
    end
    text_q.delete();
  endtask

  function void add_char(logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function void add_digits(int lo, int hi);
    repeat ($urandom_range(lo, hi)) add_char(8'("0" + $urandom_range(0, 9)));
  endfunction

  function logic [7:0] word_char(bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return srctok_pkg::CH_UNDER;
    return 8'("0" + r - 53);
  endfunction

  function void add_piece();
    piece_t p;
    p = piece_t'($urandom_range(0, P_SPACE));
    case (p)
      P_ENTRY: add_str("entry");
      P_RETURN: add_str("return");
      P_NEAR_KW: begin
        case ($urandom_range(0, 4))
          0: add_str("entr");
          1: add_str("returnx");
          2: add_str("Entry");
          3: add_str("entryy");
          default: add_str("retur");
        endcase
      end
      P_IDENT: begin
        add_char(word_char(1'b1));
        repeat ($urandom_range(0, 7)) add_char(word_char(1'b0));
      end
      P_PUNCT: add_char(puncts[$urandom_range(0, 4)]);
      P_INT: add_digits(1, 12);
      P_EDGE_NUM: begin
        case ($urandom_range(0, 5))
          0: add_str("2147483647");
          1: add_str("2147483648");
          2: add_str("9223372036854775807LL");
          3: add_str("9223372036854775808LL");
          4: add_str("0");
          default: add_str("99999999999999999999");
        endcase
      end
      P_FLOAT: begin
        add_digits(1, 3);
        add_char(srctok_pkg::CH_DOT);
        add_digits(0, 3);
        add_char(srctok_pkg::CH_F);
      end
      P_DOUBLE: begin
        add_digits(1, 3);
        add_char(srctok_pkg::CH_DOT);
        add_digits(0, 3);
        if ($urandom_range(0, 2) == 0) add_str("LL");
      end
      P_INVALID: begin
        add_digits(1, 2);
        repeat ($urandom_range(2, 3)) begin
          add_char(srctok_pkg::CH_DOT);
          add_digits(0, 2);
        end
        case ($urandom_range(0, 2))
          0: add_char(srctok_pkg::CH_F);
          1: add_str("LL");
          default: ;
        endcase
      end
      P_LLONG: begin
        add_digits(1, 8);
        add_str("LL");
      end
      P_LONE_L: begin
        add_digits(1, 4);
        add_char(srctok_pkg::CH_BIG_L);
      end
      P_COMMENT: begin
        add_str("//");
        repeat ($urandom_range(0, 6)) add_char(8'($urandom_range(32, 126)));
        add_char($urandom_range(0, 1) ? srctok_pkg::CH_LF : srctok_pkg::CH_CR);
      end
      P_SLASH: add_char(srctok_pkg::CH_SLASH);
      P_NOISE: add_char(8'($urandom_range(0, 255)));
      default: add_char(blanks[$urandom_range(0, 5)]);
    endcase
  endfunction

  initial begin
    int random_bytes;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.char_byte = '0;
    in_ch.end_of_text = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_str("return{x9}(1.5f)2LL;");
    send_text(1'b0);
    add_str("7L/");
    send_text(1'b0);
    add_char(8'hff);
    send_text(1'b0);
    add_char(8'h00);
    send_text(1'b0);

    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      repeat ($urandom_range(1, 10)) begin
        add_piece();
        if ($urandom_range(0, 1)) add_char(blanks[$urandom_range(0, 5)]);
      end
      random_bytes += text_q.size();
      send_text(1'b0);
    end
    in_ch.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
